// ===== rtl/c2d_pkg.sv =====
// ----------------------------------------------------------------------------
// c2d_pkg
// Shared sizes and helpers for the clamp-to-edge 2-D convolution block.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package c2d_pkg;

  // Store dimensions. Both must be powers of two.
  localparam int MAX_IMAGE_DIM  = 256;
  localparam int MAX_KERNEL_DIM = 64;
  localparam int PIXEL_BITS     = 16;

  // Index and address widths of the two stores.
  localparam int IMG_IW    = $clog2(MAX_IMAGE_DIM);
  localparam int KRN_IW    = (MAX_KERNEL_DIM > 1) ? $clog2(MAX_KERNEL_DIM) : 1;
  localparam int IMG_AW    = 2 * IMG_IW;
  localparam int KRN_AW    = 2 * KRN_IW;
  localparam int IMG_DEPTH = MAX_IMAGE_DIM * MAX_IMAGE_DIM;
  localparam int KRN_DEPTH = MAX_KERNEL_DIM * MAX_KERNEL_DIM;

  // Register widths are fixed by the register map.
  localparam int CFG_IMG_W = 9;
  localparam int CFG_KRN_W = 7;

  // Field widths of the stream words.
  localparam int IDX_W  = 8;
  localparam int PIN_W  = 16;
  localparam int COEF_W = 16;
  localparam int COEF_FRAC = 15;

  // Signed width that holds row + kr - cy before clamping.
  localparam int CRD_W = IDX_W + 4;

  // Datapath widths: product and sum over every tap with headroom.
  localparam int PROD_W = PIXEL_BITS + 1 + COEF_W;
  localparam int ACC_W  = PROD_W + KRN_AW + 1;
  localparam int RES_W  = ACC_W - COEF_FRAC;

  // Sequencer state of the compute engine.
  typedef struct packed {
    logic issue;   // a tap read is being issued this cycle
    logic rd_v;    // memory data of a tap is on the read ports
    logic prod_v;  // a product is waiting to be added
  } c2d_pipe_t;

endpackage

`default_nettype wire

// ===== rtl/c2d_ram.sv =====
// ----------------------------------------------------------------------------
// c2d_ram
// Generic single-write, single-read synchronous RAM with registered read.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module c2d_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 256
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

`default_nettype wire

// ===== rtl/conv2d_clamped_edges_top.sv =====
// ----------------------------------------------------------------------------
// conv2d_clamped_edges_top
// 2-D convolution of a stored image with a stored Q1.15 kernel, with source
// coordinates clamped to the image edges, rounding and saturation.
// ----------------------------------------------------------------------------
//
//  Channel   Direction  Handshake          Payload
//  -------   ---------  ---------          -------
//  s_axis    in         tvalid / tready    request word: kind, index, data
//  m_axis    out        tvalid / tready    filtered pixel and clip flag
//  apb       in         psel / penable     image and kernel size registers
//
// A coefficient or pixel write word is written to its memory at the
// accepting edge. After acceptance, a compute word reads all kw*kh taps of the
// kernel before its result is loaded into the output register: the single
// read port of each memory delivers one tap per cycle, and two further stages
// (read data, product) drain before rounding. A finished result waits in the
// output register while the next word is taken. Reset clears control state,
// sets a 256x256 image and 1x1 kernel; memory is undefined until written.
//
`timescale 1ns / 1ps
`default_nettype none

module conv2d_clamped_edges_top
  import c2d_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        rst_ni,

  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  // [7:0] row_index, [15:8] col_index, [31:16] pixel_in, [47:32] coef_in
  input  wire logic [47:0] s_axis_tdata,
  // [1:0] req_type
  input  wire logic [1:0]  s_axis_tuser,

  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  // [15:0] out_pixel
  output logic [15:0]      m_axis_tdata,
  // [0] saturated
  output logic [0:0]       m_axis_tuser,

  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [3:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);

  // Request kinds carried in tuser.
  localparam logic [1:0] REQ_COEF    = 2'd0;
  localparam logic [1:0] REQ_PIXEL   = 2'd1;
  localparam logic [1:0] REQ_COMPUTE = 2'd2;

  // Register indexes (byte address / 4).
  localparam logic [1:0] REG_IMG_W = 2'd0;
  localparam logic [1:0] REG_IMG_H = 2'd1;
  localparam logic [1:0] REG_KRN_W = 2'd2;
  localparam logic [1:0] REG_KRN_H = 2'd3;

  // Sequencer states.
  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_RUN   = 2'd1;
  localparam logic [1:0] ST_DRAIN = 2'd2;
  localparam logic [1:0] ST_DONE  = 2'd3;

  localparam logic [RES_W-1:0] PIX_MAX   = RES_W'((64'd1 << PIXEL_BITS) - 64'd1);
  localparam logic [ACC_W-1:0] ROUND_ADD = ACC_W'(64'd1 << (COEF_FRAC - 1));

  // --------------------------------------------------------------------------
  // Configuration registers
  // --------------------------------------------------------------------------
  logic [CFG_IMG_W-1:0] img_w_q, img_h_q;
  logic [CFG_KRN_W-1:0] krn_w_q, krn_h_q;
  logic                 cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      img_w_q <= CFG_IMG_W'(256);
      img_h_q <= CFG_IMG_W'(256);
      krn_w_q <= CFG_KRN_W'(1);
      krn_h_q <= CFG_KRN_W'(1);
    end else if (cfg_wr) begin
      unique case (paddr[3:2])
        REG_IMG_W: img_w_q <= pwdata[CFG_IMG_W-1:0];
        REG_IMG_H: img_h_q <= pwdata[CFG_IMG_W-1:0];
        REG_KRN_W: krn_w_q <= pwdata[CFG_KRN_W-1:0];
        REG_KRN_H: krn_h_q <= pwdata[CFG_KRN_W-1:0];
        default:   ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[3:2])
      REG_IMG_W: prdata = 32'(img_w_q);
      REG_IMG_H: prdata = 32'(img_h_q);
      REG_KRN_W: prdata = 32'(krn_w_q);
      REG_KRN_H: prdata = 32'(krn_h_q);
      default:   prdata = '0;
    endcase
  end

  // Effective sizes: zero acts as one, anything above the store acts as its
  // maximum.
  logic [CFG_IMG_W-1:0] img_w_eff, img_h_eff;
  logic [CFG_KRN_W-1:0] krn_w_eff, krn_h_eff;

  always_comb begin
    img_w_eff = (img_w_q == '0) ? CFG_IMG_W'(1) :
                (img_w_q > CFG_IMG_W'(MAX_IMAGE_DIM)) ? CFG_IMG_W'(MAX_IMAGE_DIM) : img_w_q;
    img_h_eff = (img_h_q == '0) ? CFG_IMG_W'(1) :
                (img_h_q > CFG_IMG_W'(MAX_IMAGE_DIM)) ? CFG_IMG_W'(MAX_IMAGE_DIM) : img_h_q;
    krn_w_eff = (krn_w_q == '0) ? CFG_KRN_W'(1) :
                (krn_w_q > CFG_KRN_W'(MAX_KERNEL_DIM)) ? CFG_KRN_W'(MAX_KERNEL_DIM) : krn_w_q;
    krn_h_eff = (krn_h_q == '0) ? CFG_KRN_W'(1) :
                (krn_h_q > CFG_KRN_W'(MAX_KERNEL_DIM)) ? CFG_KRN_W'(MAX_KERNEL_DIM) : krn_h_q;
  end

  // --------------------------------------------------------------------------
  // Input word unpacking
  // --------------------------------------------------------------------------
  logic [1:0]        in_kind;
  logic [IDX_W-1:0]  in_row, in_col;
  logic [PIN_W-1:0]  in_pix;
  logic [COEF_W-1:0] in_coef;
  logic              in_acc;

  assign in_kind = s_axis_tuser;
  assign in_row  = s_axis_tdata[7:0];
  assign in_col  = s_axis_tdata[15:8];
  assign in_pix  = s_axis_tdata[31:16];
  assign in_coef = s_axis_tdata[47:32];

  logic [1:0] state_q, state_d;

  assign s_axis_tready = (state_q == ST_IDLE);
  assign in_acc        = s_axis_tvalid && s_axis_tready;

  // Write ports: writes outside a store are dropped.
  logic              img_we, krn_we;
  logic [IMG_AW-1:0] img_waddr;
  logic [KRN_AW-1:0] krn_waddr;

  assign img_we = in_acc && (in_kind == REQ_PIXEL) &&
                  (32'(in_row) < MAX_IMAGE_DIM) && (32'(in_col) < MAX_IMAGE_DIM);
  assign krn_we = in_acc && (in_kind == REQ_COEF) &&
                  (32'(in_row) < MAX_KERNEL_DIM) && (32'(in_col) < MAX_KERNEL_DIM);
  assign img_waddr = (IMG_AW'(in_row) << IMG_IW) | IMG_AW'(in_col);
  assign krn_waddr = (KRN_AW'(in_row) << KRN_IW) | KRN_AW'(in_col);

  // --------------------------------------------------------------------------
  // Tap sequencer
  // --------------------------------------------------------------------------
  logic [IDX_W-1:0]  row_q, col_q;
  logic [KRN_IW-1:0] kr_q, kc_q;
  logic              kc_last, kr_last;
  c2d_pipe_t         pipe;
  logic              rd_v_q, prod_v_q;

  assign kc_last = (CFG_KRN_W'(kc_q) == krn_w_eff - CFG_KRN_W'(1));
  assign kr_last = (CFG_KRN_W'(kr_q) == krn_h_eff - CFG_KRN_W'(1));

  assign pipe.issue  = (state_q == ST_RUN);
  assign pipe.rd_v   = rd_v_q;
  assign pipe.prod_v = prod_v_q;

  // Source coordinates, clamped into the image.
  logic [CRD_W-1:0]  sr_raw, sc_raw;
  logic [IMG_IW-1:0] sr, sc;
  logic [CFG_IMG_W-1:0] h_last, w_last;

  assign h_last = img_h_eff - CFG_IMG_W'(1);
  assign w_last = img_w_eff - CFG_IMG_W'(1);
  assign sr_raw = CRD_W'(row_q) + CRD_W'(kr_q) - CRD_W'(krn_h_eff >> 1);
  assign sc_raw = CRD_W'(col_q) + CRD_W'(kc_q) - CRD_W'(krn_w_eff >> 1);

  always_comb begin
    priority if (sr_raw[CRD_W-1]) begin
      sr = '0;
    end else if (sr_raw > CRD_W'(h_last)) begin
      sr = h_last[IMG_IW-1:0];
    end else begin
      sr = sr_raw[IMG_IW-1:0];
    end
    priority if (sc_raw[CRD_W-1]) begin
      sc = '0;
    end else if (sc_raw > CRD_W'(w_last)) begin
      sc = w_last[IMG_IW-1:0];
    end else begin
      sc = sc_raw[IMG_IW-1:0];
    end
  end

  logic [IMG_AW-1:0] img_raddr;
  logic [KRN_AW-1:0] krn_raddr;
  logic [PIXEL_BITS-1:0] img_rdata;
  logic [COEF_W-1:0]     krn_rdata;

  assign img_raddr = (IMG_AW'(sr) << IMG_IW) | IMG_AW'(sc);
  assign krn_raddr = (KRN_AW'(kr_q) << KRN_IW) | KRN_AW'(kc_q);

  c2d_ram #(
    .WIDTH(PIXEL_BITS),
    .DEPTH(IMG_DEPTH)
  ) u_img_ram (
    .clk_i  (clk_i),
    .we_i   (img_we),
    .waddr_i(img_waddr),
    .wdata_i(in_pix[PIXEL_BITS-1:0]),
    .re_i   (pipe.issue),
    .raddr_i(img_raddr),
    .rdata_o(img_rdata)
  );

  c2d_ram #(
    .WIDTH(COEF_W),
    .DEPTH(KRN_DEPTH)
  ) u_krn_ram (
    .clk_i  (clk_i),
    .we_i   (krn_we),
    .waddr_i(krn_waddr),
    .wdata_i(in_coef),
    .re_i   (pipe.issue),
    .raddr_i(krn_raddr),
    .rdata_o(krn_rdata)
  );

  // --------------------------------------------------------------------------
  // Multiply-accumulate and result
  // --------------------------------------------------------------------------
  logic signed [PROD_W-1:0] prod_q, prod_d;
  logic signed [ACC_W-1:0]  acc_q, rnd;
  logic signed [RES_W-1:0]  res_s;
  logic [PIXEL_BITS-1:0]    res_pix;
  logic                     res_sat;
  logic                     out_free;

  assign prod_d = $signed({1'b0, img_rdata}) * $signed(krn_rdata);

  // Round to nearest with ties upward, then clip into the pixel range.
  assign rnd   = acc_q + $signed(ROUND_ADD);
  assign res_s = rnd[ACC_W-1:COEF_FRAC];

  always_comb begin
    priority if (rnd[ACC_W-1]) begin
      res_pix = '0;
      res_sat = 1'b1;
    end else if ($unsigned(res_s) > PIX_MAX) begin
      res_pix = PIX_MAX[PIXEL_BITS-1:0];
      res_sat = 1'b1;
    end else begin
      res_pix = res_s[PIXEL_BITS-1:0];
      res_sat = 1'b0;
    end
  end

  assign out_free = !m_axis_tvalid || m_axis_tready;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE:  if (in_acc && (in_kind == REQ_COMPUTE)) state_d = ST_RUN;
      ST_RUN:   if (kc_last && kr_last) state_d = ST_DRAIN;
      ST_DRAIN: if (!pipe.rd_v && !pipe.prod_v) state_d = ST_DONE;
      ST_DONE:  if (out_free) state_d = ST_IDLE;
      default:  state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= ST_IDLE;
      rd_v_q        <= 1'b0;
      prod_v_q      <= 1'b0;
      kr_q          <= '0;
      kc_q          <= '0;
      m_axis_tvalid <= 1'b0;
    end else begin
      state_q  <= state_d;
      rd_v_q   <= pipe.issue;
      prod_v_q <= pipe.rd_v;

      if (state_q == ST_IDLE) begin
        kr_q <= '0;
        kc_q <= '0;
      end else if (pipe.issue) begin
        if (kc_last) begin
          kc_q <= '0;
          kr_q <= kr_q + KRN_IW'(1);
        end else begin
          kc_q <= kc_q + KRN_IW'(1);
        end
      end

      if ((state_q == ST_DONE) && out_free) begin
        m_axis_tvalid <= 1'b1;
      end else if (m_axis_tready) begin
        m_axis_tvalid <= 1'b0;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    if (in_acc && (in_kind == REQ_COMPUTE)) begin
      row_q <= in_row;
      col_q <= in_col;
      acc_q <= '0;
    end else if (pipe.prod_v) begin
      acc_q <= acc_q + ACC_W'(prod_q);
    end
    if (pipe.rd_v) begin
      prod_q <= prod_d;
    end
    if ((state_q == ST_DONE) && out_free) begin
      m_axis_tdata <= 16'(res_pix);
      m_axis_tuser <= res_sat;
    end
  end

  // --------------------------------------------------------------------------
  // Checks
  // --------------------------------------------------------------------------
  a_result_from_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_axis_tvalid) |-> $past(state_q) == ST_DONE)
    else $error("result appeared without a finished compute");

  a_pipe_empty_at_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_DONE |-> !rd_v_q && !prod_v_q)
    else $error("taps still in flight when rounding");

  a_read_only_in_run: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rd_v_q |-> $past(state_q) == ST_RUN)
    else $error("memory read outside the tap sweep");

  a_sat_at_limit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser[0] |-> m_axis_tdata == 16'h0000 ||
                                         m_axis_tdata == 16'hFFFF)
    else $error("clip flag set on an unclipped pixel");

endmodule

`default_nettype wire

// ===== sim/tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the clamp-to-edge 2-D convolution block. It fills
// the image and kernel memories through the request stream and asks for
// filtered pixels. A local model predicts every result word. The bench runs
// through several image and kernel sizes, set over the register port. The
// size extremes, rounding ties, saturation at both ends, ignored writes and
// clamped borders are covered under several patterns of stream idling.
// ----------------------------------------------------------------------------

module tb;
  import c2d_pkg::*;

  typedef enum logic [1:0] {
    REQ_COEF  = 2'd0,
    REQ_PIXEL = 2'd1,
    REQ_CONV  = 2'd2,
    REQ_NONE  = 2'd3
  } req_kind_e;

  typedef struct packed {
    req_kind_e   kind;
    logic [7:0]  row;
    logic [7:0]  col;
    logic [15:0] pix;
    logic [15:0] coef;
  } req_t;

  typedef struct packed {
    logic [15:0] px;
    logic        sat;
  } px_result_t;

  localparam int REG_IMG_W = 0;
  localparam int REG_IMG_H = 1;
  localparam int REG_KRN_W = 2;
  localparam int REG_KRN_H = 3;

  localparam int STALL_LIMIT = 20000;
  localparam int HOLD_CYCLES = 400;

  logic        clk_i;
  logic        rst_ni         = 1'b0;
  logic        s_axis_tvalid  = 1'b0;
  logic        s_axis_tready;
  logic [47:0] s_axis_tdata   = '0;
  logic [1:0]  s_axis_tuser   = '0;
  logic        m_axis_tvalid;
  logic        m_axis_tready  = 1'b0;
  logic [15:0] m_axis_tdata;
  logic [0:0]  m_axis_tuser;
  logic        psel           = 1'b0;
  logic        penable        = 1'b0;
  logic        pwrite         = 1'b0;
  logic [3:0]  paddr          = '0;
  logic [31:0] pwdata         = '0;
  logic [31:0] prdata;
  logic        pready;

  conv2d_clamped_edges_top dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready)
  );

  always begin
    clk_i = 1'b0;
    #5;
    clk_i = 1'b1;
    #5;
  end

  // Size registers as last written; the model and the request generator both
  // read them. They only change while the block is idle.
  logic [8:0] img_w_r = 9'd256;
  logic [8:0] img_h_r = 9'd256;
  logic [6:0] krn_w_r = 7'd1;
  logic [6:0] krn_h_r = 7'd1;

  // Model memories, updated as request words are accepted.
  logic [15:0]        img_px [IMG_DEPTH];
  logic signed [15:0] krn_cf [KRN_DEPTH];

  // Entries that the generator has already queued a write for. A compute
  // request is only queued once its whole footprint is covered.
  bit img_set [IMG_DEPTH];
  bit krn_set [KRN_DEPTH];

  req_t       req_q [$];
  px_result_t expected_px_q [$];
  req_t       nxt_req;
  px_result_t exp_px;

  int n_pushed = 0;
  int n_taken = 0;
  int n_fail = 0;
  int stuck_cycles = 0;
  int send_gap_pct = 0;
  int recv_stall_pct = 0;
  int hold_tok = 0;
  int hold_seen = 0;
  int hold_left = 0;
  logic in_fire = 1'b0;

  function automatic int eff_span(input int v, input int maxv);
    if (v == 0) return 1;
    if (v > maxv) return maxv;
    return v;
  endfunction

  function automatic int clip(input int v, input int hi);
    if (v < 0) return 0;
    if (v > hi) return hi;
    return v;
  endfunction

  // Applies one accepted request word to the model and queues the filtered
  // pixel that a compute request must produce.
  task automatic filter_word(input req_t w);
    int wid, hgt, kwid, khgt, kr, kc, sr, sc;
    longint acc, rnd;
    px_result_t res;
    case (w.kind)
      REQ_COEF: begin
        if (int'(w.row) < MAX_KERNEL_DIM && int'(w.col) < MAX_KERNEL_DIM)
          krn_cf[int'(w.row) * MAX_KERNEL_DIM + int'(w.col)] = w.coef;
      end
      REQ_PIXEL: begin
        img_px[int'(w.row) * MAX_IMAGE_DIM + int'(w.col)] = w.pix;
      end
      REQ_CONV: begin
        wid  = eff_span(img_w_r, MAX_IMAGE_DIM);
        hgt  = eff_span(img_h_r, MAX_IMAGE_DIM);
        kwid = eff_span(krn_w_r, MAX_KERNEL_DIM);
        khgt = eff_span(krn_h_r, MAX_KERNEL_DIM);
        acc  = 0;
        for (kr = 0; kr < khgt; kr++) begin
          sr = clip(int'(w.row) + kr - khgt / 2, hgt - 1);
          for (kc = 0; kc < kwid; kc++) begin
            sc = clip(int'(w.col) + kc - kwid / 2, wid - 1);
            acc += longint'(img_px[sr * MAX_IMAGE_DIM + sc]) *
                   longint'(krn_cf[kr * MAX_KERNEL_DIM + kc]);
          end
        end
        // Q1.15 scaling, half rounds up, then clip to the pixel range.
        rnd = acc + 64'sd16384;
        res.sat = 1'b0;
        if (rnd < 0) begin
          res.px  = 16'h0000;
          res.sat = 1'b1;
        end else if ((rnd >>> 15) > 65535) begin
          res.px  = 16'hFFFF;
          res.sat = 1'b1;
        end else begin
          res.px = 16'(rnd >>> 15);
        end
        expected_px_q.push_back(res);
      end
      default: ;
    endcase
  endtask

  function automatic logic [15:0] rnd_pix();
    int pick;
    pick = $urandom_range(7);
    if (pick == 0) return 16'h0000;
    if (pick == 1) return 16'hFFFF;
    return 16'($urandom);
  endfunction

  // Mostly modest coefficients so that sums stay in range, some full-scale.
  function automatic logic [15:0] rnd_coef();
    if ($urandom_range(3) == 0) return 16'($urandom);
    return 16'($urandom_range(16384) - 4096);
  endfunction

  task automatic push_word(input req_kind_e kind, input int row, input int col,
                           input logic [15:0] pix, input logic [15:0] coef);
    req_t w;
    w.kind = kind;
    w.row  = 8'(row);
    w.col  = 8'(col);
    w.pix  = pix;
    w.coef = coef;
    req_q.push_back(w);
    n_pushed++;
    if (kind == REQ_PIXEL)
      img_set[int'(w.row) * MAX_IMAGE_DIM + int'(w.col)] = 1'b1;
    if (kind == REQ_COEF && int'(w.row) < MAX_KERNEL_DIM && int'(w.col) < MAX_KERNEL_DIM)
      krn_set[int'(w.row) * MAX_KERNEL_DIM + int'(w.col)] = 1'b1;
  endtask

  // Queues a compute request, preceded by writes for any tap or source pixel
  // in its footprint that has never been written.
  task automatic add_compute(input int row, input int col);
    int wid, hgt, kwid, khgt, kr, kc, sr, sc;
    wid  = eff_span(img_w_r, MAX_IMAGE_DIM);
    hgt  = eff_span(img_h_r, MAX_IMAGE_DIM);
    kwid = eff_span(krn_w_r, MAX_KERNEL_DIM);
    khgt = eff_span(krn_h_r, MAX_KERNEL_DIM);
    for (kr = 0; kr < khgt; kr++) begin
      sr = clip(row + kr - khgt / 2, hgt - 1);
      for (kc = 0; kc < kwid; kc++) begin
        sc = clip(col + kc - kwid / 2, wid - 1);
        if (!krn_set[kr * MAX_KERNEL_DIM + kc])
          push_word(REQ_COEF, kr, kc, rnd_pix(), rnd_coef());
        if (!img_set[sr * MAX_IMAGE_DIM + sc])
          push_word(REQ_PIXEL, sr, sc, rnd_pix(), 16'($urandom));
      end
    end
    push_word(REQ_CONV, row, col, 16'($urandom), 16'($urandom));
  endtask

  // Random mix of requests. Indices mostly fall inside the configured sizes;
  // a quarter of image indices and an eighth of kernel indices go anywhere.
  task automatic add_random(input int n);
    int wid, hgt, kwid, khgt, sel, i, r, c;
    wid  = eff_span(img_w_r, MAX_IMAGE_DIM);
    hgt  = eff_span(img_h_r, MAX_IMAGE_DIM);
    kwid = eff_span(krn_w_r, MAX_KERNEL_DIM);
    khgt = eff_span(krn_h_r, MAX_KERNEL_DIM);
    for (i = 0; i < n; i++) begin
      sel = $urandom_range(99);
      r = ($urandom_range(3) == 0) ? $urandom_range(255) : $urandom_range(hgt - 1);
      c = ($urandom_range(3) == 0) ? $urandom_range(255) : $urandom_range(wid - 1);
      if (sel < 40) begin
        add_compute(r, c);
      end else if (sel < 65) begin
        push_word(REQ_PIXEL, r, c, rnd_pix(), 16'($urandom));
      end else if (sel < 92) begin
        r = ($urandom_range(7) == 0) ? $urandom_range(255) : $urandom_range(khgt - 1);
        c = ($urandom_range(7) == 0) ? $urandom_range(255) : $urandom_range(kwid - 1);
        push_word(REQ_COEF, r, c, 16'($urandom), rnd_coef());
      end else begin
        push_word(REQ_NONE, r, c, 16'($urandom), 16'($urandom));
      end
    end
  endtask

  task automatic cfg_write(input int idx, input int val);
    @(negedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= 4'(idx * 4);
    pwdata  <= 32'(val);
    @(negedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    case (idx)
      REG_IMG_W: img_w_r = 9'(val);
      REG_IMG_H: img_h_r = 9'(val);
      REG_KRN_W: krn_w_r = 7'(val);
      REG_KRN_H: krn_h_r = 7'(val);
      default: ;
    endcase
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  task automatic set_sizes(input int w, input int h, input int kw, input int kh);
    cfg_write(REG_IMG_W, w);
    cfg_write(REG_IMG_H, h);
    cfg_write(REG_KRN_W, kw);
    cfg_write(REG_KRN_H, kh);
  endtask

  // Waits until every queued word has been taken and every filtered pixel
  // has come back, then lets a few more cycles pass for words with no result.
  task automatic wait_idle(input int tail);
    do @(negedge clk_i); while (n_taken != n_pushed || expected_px_q.size() != 0);
    repeat (tail) @(negedge clk_i);
  endtask

  // Request driver: presents the next word once the current one is taken,
  // with random gaps set by send_gap_pct.
  always @(negedge clk_i) begin
    if (!s_axis_tvalid || in_fire) begin
      if (req_q.size() != 0 && $urandom_range(99) >= send_gap_pct) begin
        nxt_req = req_q.pop_front();
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {nxt_req.coef, nxt_req.pix, nxt_req.col, nxt_req.row};
        s_axis_tuser  <= nxt_req.kind;
      end else begin
        s_axis_tvalid <= 1'b0;
      end
    end
  end

  // Result receiver: random stalls, plus a long hold-off each time hold_tok
  // is bumped by the stimulus process.
  always @(negedge clk_i) begin
    if (hold_tok != hold_seen) begin
      hold_seen = hold_tok;
      hold_left = HOLD_CYCLES;
    end
    if (hold_left > 0) begin
      hold_left--;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // Monitor: feeds accepted request words to the model, checks result words
  // in order, and ends the run if nothing moves for too long.
  always @(posedge clk_i) begin
    in_fire <= s_axis_tvalid && s_axis_tready;
    if (rst_ni && s_axis_tvalid && s_axis_tready) begin
      filter_word(req_t'({s_axis_tuser, s_axis_tdata[7:0], s_axis_tdata[15:8],
                          s_axis_tdata[31:16], s_axis_tdata[47:32]}));
      n_taken++;
    end
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (expected_px_q.size() == 0) begin
        $error("unexpected result word: out_pixel %0d, saturated %0d",
               m_axis_tdata, m_axis_tuser[0]);
        n_fail++;
      end else begin
        exp_px = expected_px_q.pop_front();
        if (m_axis_tdata !== exp_px.px) begin
          $error("out_pixel: expected %0d, actual %0d", exp_px.px, m_axis_tdata);
          n_fail++;
        end
        if (m_axis_tuser[0] !== exp_px.sat) begin
          $error("saturated: expected %0d, actual %0d", exp_px.sat, m_axis_tuser[0]);
          n_fail++;
        end
      end
    end
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
        (psel && penable && pwrite && pready))
      stuck_cycles = 0;
    else
      stuck_cycles++;
    if (stuck_cycles >= STALL_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  initial begin
    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // Reset sizes, 1x1 kernel: rounding ties, extreme coefficients,
    // out-of-range kernel writes and an unknown request kind.
    @(posedge clk_i);
    push_word(REQ_COEF, 0, 0, 16'h0000, 16'h4000);
    push_word(REQ_PIXEL, 0, 0, 16'h0001, 16'h0000);
    add_compute(0, 0);
    push_word(REQ_PIXEL, 255, 255, 16'hFFFF, 16'hFFFF);
    add_compute(255, 255);
    push_word(REQ_COEF, 0, 0, 16'hFFFF, 16'h7FFF);
    add_compute(255, 255);
    push_word(REQ_COEF, 0, 0, 16'h0000, 16'h8000);
    add_compute(255, 255);
    push_word(REQ_COEF, 0, 0, 16'h0000, 16'hC000);
    add_compute(0, 0);
    push_word(REQ_COEF, 0, 0, 16'h0000, 16'hBFFF);
    add_compute(0, 0);
    push_word(REQ_COEF, 64, 0, 16'h0000, 16'h4000);
    push_word(REQ_COEF, 0, 64, 16'h0000, 16'h4000);
    push_word(REQ_COEF, 255, 255, 16'hFFFF, 16'h7FFF);
    add_compute(0, 0);
    push_word(REQ_NONE, 255, 255, 16'hFFFF, 16'hFFFF);
    push_word(REQ_PIXEL, 128, 0, 16'h0000, 16'hFFFF);
    add_compute(128, 0);

    // Small image, 2x1 kernel: positive saturation and clamped borders,
    // then random traffic with the sender idling half the time.
    wait_idle(8);
    set_sizes(5, 3, 2, 1);
    @(posedge clk_i);
    send_gap_pct = 51;
    push_word(REQ_COEF, 0, 0, 16'h0000, 16'h7FFF);
    push_word(REQ_COEF, 0, 1, 16'h0000, 16'h7FFF);
    push_word(REQ_PIXEL, 0, 3, 16'hFFFF, 16'h0000);
    push_word(REQ_PIXEL, 0, 4, 16'hFFFF, 16'h0000);
    add_compute(0, 4);
    add_compute(200, 255);
    add_compute(0, 0);
    add_random(35);

    // Zero and over-range register values: widths act as 1, height and the
    // kernel height as their maxima. Receiver stalls half the time.
    wait_idle(8);
    set_sizes(0, 511, 0, 127);
    @(posedge clk_i);
    send_gap_pct = 0;
    recv_stall_pct = 51;
    add_random(30);

    // Largest image and kernel: only two compute requests, as each walks
    // every tap of the full kernel.
    wait_idle(8);
    set_sizes(256, 256, 64, 64);
    @(posedge clk_i);
    send_gap_pct = 27;
    recv_stall_pct = 27;
    add_compute(0, 0);
    add_compute($urandom_range(255), $urandom_range(255));

    // Kernel 4 wide, 5 high. The receiver holds off for a long stretch while
    // requests keep coming, then the sender pauses until all results are in.
    wait_idle(8);
    set_sizes(37, 200, 4, 5);
    @(posedge clk_i);
    add_random(25);
    hold_tok++;
    wait_idle(0);
    @(posedge clk_i);
    add_random(25);

    // One-pixel image under a 3x3 kernel, no idling.
    wait_idle(8);
    set_sizes(1, 1, 3, 3);
    @(posedge clk_i);
    send_gap_pct = 0;
    recv_stall_pct = 0;
    add_random(25);

    wait_idle(64);
    if (n_fail == 0)
      $display("PASS");
    else
      $display("FAIL");
    $finish;
  end

endmodule
